// ===== src/streaming_top_k_selector_assert.svh =====
// Assertion macros for the top-k selector. Each expects clk and rst_n in scope.
`ifndef STREAMING_TOP_K_SELECTOR_ASSERT_SVH
`define STREAMING_TOP_K_SELECTOR_ASSERT_SVH

`ifndef SYNTH
`define STKS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top-k selector check failed");
`define STKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top-k selector check failed");
`else
`define STKS_ASSERT_SAME(label, ante, cons)
`define STKS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/stks_pkg.sv =====
package stks_pkg;

  localparam int SCORE_W      = 16;
  localparam int ID_W         = 31;
  localparam int KC_W         = 5;
  localparam int MAX_KEEP_DEF = 16;
  localparam logic [KC_W-1:0] KEEP_RESET = 5'd8;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } entry_t;

  // What the chain does this cycle
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_REPLACE = 2'd2,
    MODE_DRAIN   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  occ;      // cell holds a live entry
    logic  at_tail;  // first free cell
  } cell_ctrl_t;

  // true when a orders below b by (score, id)
  function automatic logic lower_than(input entry_t a, input entry_t b);
    logic res;
    if (a.score != b.score) begin
      res = ($signed(a.score) < $signed(b.score));
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

// ===== src/stks_in_if.sv =====
interface stks_in_if import stks_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic [ID_W-1:0]           node_id;
  logic                      last_candidate;

  modport source (output valid, score, node_id, last_candidate, input ready);
  modport sink (input valid, score, node_id, last_candidate, output ready);
endinterface

// ===== src/stks_out_if.sv =====
interface stks_out_if import stks_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] kept_score;
  logic [ID_W-1:0]           kept_id;
  logic                      final_result;

  modport source (output valid, kept_score, kept_id, final_result, input ready);
  modport sink (input valid, kept_score, kept_id, final_result, output ready);
endinterface

// ===== src/stks_cfg_if.sv =====
interface stks_cfg_if import stks_pkg::*;;
  logic            valid;
  logic            ready;
  logic [KC_W-1:0] keep_count;

  modport source (output valid, keep_count, input ready);
  modport sink (input valid, keep_count, output ready);
endinterface

// ===== src/stks_cell.sv =====
module stks_cell import stks_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     cand,
  input  entry_t     lo_e,
  input  logic       lo_ab,
  input  entry_t     hi_e,
  input  logic       hi_lt,
  output entry_t     e,
  output logic       ab,
  output logic       lt
);

  entry_t e_r, e_nxt;
  logic   cand_below;

  assign cand_below = lower_than(cand, e_r);
  // ab: candidate sorts below this entry, lt: entry sorts at or below candidate
  assign ab = ctrl.occ & cand_below;
  assign lt = ctrl.occ & ~cand_below;
  assign e  = e_r;

  always_comb begin
    e_nxt = e_r;
    unique case (ctrl.mode)
      MODE_INSERT: begin
        if (lo_ab) begin
          e_nxt = lo_e;
        end else if (ab || ctrl.at_tail) begin
          e_nxt = cand;
        end
      end
      MODE_REPLACE: begin
        // head drops out, lower entries slide down, candidate lands in the gap
        if (hi_lt) begin
          e_nxt = hi_e;
        end else if (lt) begin
          e_nxt = cand;
        end
      end
      MODE_DRAIN: e_nxt = hi_e;
      MODE_IDLE:  e_nxt = e_r;
      default:    e_nxt = e_r;
    endcase
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule

// ===== src/streaming_top_k_selector.sv =====
// Streaming top-k selector. Candidates (score, node_id) enter at one per cycle and are kept
// in a chain of MAX_KEEP cells sorted ascending by (score, id); the head cell holds the
// minimum. While fewer than keep_count entries are held every candidate is inserted in
// place; once full, a candidate whose score is strictly above the head's replaces it.
// keep_count is clamped to 1..MAX_KEEP. A candidate flagged last_candidate is absorbed like
// any other, then the input stalls while the held entries leave from the head, lowest first,
// one result per cycle while out_if.ready is high; final_result marks the last of them and
// the store is then empty. Throughput is one candidate per cycle outside a drain; after a last
// candidate the input stalls while the n held entries drain through the head cell, and for as
// long as out_if.ready is low.
// The store needs no clearing after reset.
`include "streaming_top_k_selector_assert.svh"

module streaming_top_k_selector import stks_pkg::*; #(
  parameter int MAX_KEEP = MAX_KEEP_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stks_in_if.sink   in_if,
  stks_out_if.source out_if,
  stks_cfg_if.sink  cfg_if
);

  localparam int CW   = $clog2(MAX_KEEP + 1);
  localparam int CMPW = (CW > KC_W) ? CW : KC_W;

  logic [KC_W-1:0] keep_r, keep_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            drain_r, drain_nxt;

  logic [CMPW-1:0] kc_ext, keff, cnt_ext;
  logic            full, in_fire, out_fire, beats_head;
  mode_t           mode;
  entry_t          cand, head;

  entry_t              cell_e [MAX_KEEP];
  logic [MAX_KEEP-1:0] cell_ab, cell_lt;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = ~drain_r;
  assign in_fire      = in_if.valid & in_if.ready;
  assign out_fire     = out_if.valid & out_if.ready;

  assign cand.score = in_if.score;
  assign cand.id    = in_if.node_id;
  assign head       = cell_e[0];

  always_comb begin
    kc_ext  = CMPW'(keep_r);
    cnt_ext = CMPW'(cnt_r);
    if (kc_ext == '0) begin
      keff = CMPW'(1);
    end else if (kc_ext > CMPW'(MAX_KEEP)) begin
      keff = CMPW'(MAX_KEEP);
    end else begin
      keff = kc_ext;
    end
  end

  assign full       = (cnt_ext >= keff);
  assign beats_head = ($signed(cand.score) > $signed(head.score));

  always_comb begin
    mode      = MODE_IDLE;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    keep_nxt  = keep_r;
    if (cfg_if.valid) begin
      keep_nxt = cfg_if.keep_count;
    end
    if (in_fire) begin
      if (!full) begin
        mode    = MODE_INSERT;
        cnt_nxt = cnt_r + CW'(1);
      end else if (beats_head) begin
        mode = MODE_REPLACE;
      end
      if (in_if.last_candidate) begin
        drain_nxt = 1'b1;
      end
    end else if (out_fire) begin
      mode    = MODE_DRAIN;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        drain_nxt = 1'b0;
      end
    end
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     lo_e, hi_e;
    logic       lo_ab, hi_lt;

    assign ctrl.mode    = mode;
    assign ctrl.occ     = (cnt_r > CW'(i));
    assign ctrl.at_tail = (cnt_r == CW'(i));

    if (i == 0) begin : g_lo_edge
      assign lo_e  = cell_e[i];
      assign lo_ab = 1'b0;
    end else begin : g_lo
      assign lo_e  = cell_e[i-1];
      assign lo_ab = cell_ab[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_hi_edge
      assign hi_e  = cell_e[i];
      assign hi_lt = 1'b0;
    end else begin : g_hi
      assign hi_e  = cell_e[i+1];
      assign hi_lt = cell_lt[i+1];
    end

    stks_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .cand  (cand),
      .lo_e  (lo_e),
      .lo_ab (lo_ab),
      .hi_e  (hi_e),
      .hi_lt (hi_lt),
      .e     (cell_e[i]),
      .ab    (cell_ab[i]),
      .lt    (cell_lt[i])
    );
  end

  assign out_if.valid        = drain_r;
  assign out_if.kept_score   = head.score;
  assign out_if.kept_id      = head.id;
  assign out_if.final_result = (cnt_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r  <= KEEP_RESET;
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      keep_r  <= keep_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

  `STKS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_KEEP))
  `STKS_ASSERT_SAME(a_drain_nonempty, drain_r, cnt_r != '0)
  `STKS_ASSERT_NEXT(a_final_empties, out_fire && out_if.final_result, cnt_r == '0 && !drain_r)
  `STKS_ASSERT_NEXT(a_insert_grows, in_fire && !full, cnt_r == CW'($past(cnt_r) + 1'b1))

endmodule
